[hw/rtl/msd_pkg.sv]
// shared types and constants for the i2s mic slot detector
package msd_pkg;

    localparam int WORD_W   = 32;
    localparam int SAMPLE_W = 24;
    localparam int COUNT_W  = 7;
    localparam int VOTE_W   = 8;

    localparam logic [VOTE_W-1:0] VOTE_LIMIT_RESET = 8'd50;
    localparam logic [VOTE_W-1:0] VOTE_MAX         = 8'hFF;

    localparam logic SLOT_LEFT  = 1'b0;
    localparam logic SLOT_RIGHT = 1'b1;

    // per-block statistics handed from the front to the back
    typedef struct packed {
        logic [COUNT_W-1:0]         nonzero_left;
        logic [COUNT_W-1:0]         nonzero_right;
        logic [COUNT_W-1:0]         live_left;
        logic [COUNT_W-1:0]         live_right;
        logic signed [SAMPLE_W-1:0] sample_min;
        logic signed [SAMPLE_W-1:0] sample_max;
        logic signed [WORD_W-1:0]   last_left;
        logic signed [WORD_W-1:0]   last_right;
        logic                       chosen_slot;
        logic                       slot_switched;
    } blk_stats_t;

endpackage

[hw/rtl/msd_front.sv]
// front end: accepts frames, accumulates block statistics and runs the slot vote
module msd_front #(
    parameter int BLOCK_FRAMES = 64,
    parameter int CNT_W        = 7,
    parameter int SUM_W        = 31
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [msd_pkg::WORD_W-1:0]  left_word,
    input  logic signed [msd_pkg::WORD_W-1:0]  right_word,
    input  logic                               block_end,
    input  logic                               cfg_valid,
    input  logic [msd_pkg::VOTE_W-1:0]         vote_limit,
    input  logic                               q_full,
    output logic                               push,
    output msd_pkg::blk_stats_t                push_stats,
    output logic signed [SUM_W-1:0]            push_sum,
    output logic [CNT_W-1:0]                   push_frames
);
    import msd_pkg::*;

    logic [CNT_W-1:0]          nz_l_reg, nz_r_reg, lv_l_reg, lv_r_reg, frames_reg;
    logic [CNT_W-1:0]          nz_l_next, nz_r_next, lv_l_next, lv_r_next, frames_next;
    logic signed [SAMPLE_W-1:0] min_reg, max_reg, min_next, max_next, sample;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic                      slot_reg;
    logic [VOTE_W-1:0]         vote_reg, limit_reg, vote_inc;
    logic [CNT_W-1:0]          quarter, half;
    logic                      fire, closes, first, want, do_switch;
    logic                      live_l, live_r;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;

    // per-frame classification and accumulation
    always_comb
    begin
        live_l      = (left_word[31:8] != '0) && (left_word[31:8] != '1);
        live_r      = (right_word[31:8] != '0) && (right_word[31:8] != '1);
        sample      = (slot_reg == SLOT_RIGHT) ? signed'(right_word[31:8])
                                               : signed'(left_word[31:8]);
        nz_l_next   = nz_l_reg + CNT_W'(left_word != '0);
        nz_r_next   = nz_r_reg + CNT_W'(right_word != '0);
        lv_l_next   = lv_l_reg + CNT_W'(live_l);
        lv_r_next   = lv_r_reg + CNT_W'(live_r);
        frames_next = frames_reg + CNT_W'(1);
        first       = (frames_reg == '0);
        min_next    = (first || sample < min_reg) ? sample : min_reg;
        max_next    = (first || sample > max_reg) ? sample : max_reg;
        sum_next    = sum_reg + SUM_W'(sample);
        closes      = block_end || (frames_next == CNT_W'(BLOCK_FRAMES));
    end

    // slot vote on the closing frame
    always_comb
    begin
        quarter = frames_next >> 2;
        half    = frames_next >> 1;
        if (lv_l_next < quarter && lv_r_next > half)
            want = SLOT_RIGHT;
        else if (lv_r_next < quarter && lv_l_next > half)
            want = SLOT_LEFT;
        else
            want = slot_reg;
        vote_inc  = (vote_reg == VOTE_MAX) ? VOTE_MAX : vote_reg + VOTE_W'(1);
        do_switch = (want != slot_reg) && (vote_inc > limit_reg);
    end

    // block record pushed into the queue
    always_comb
    begin
        push                     = fire && closes;
        push_stats.nonzero_left  = COUNT_W'(nz_l_next);
        push_stats.nonzero_right = COUNT_W'(nz_r_next);
        push_stats.live_left     = COUNT_W'(lv_l_next);
        push_stats.live_right    = COUNT_W'(lv_r_next);
        push_stats.sample_min    = min_next;
        push_stats.sample_max    = max_next;
        push_stats.last_left     = left_word;
        push_stats.last_right    = right_word;
        push_stats.chosen_slot   = do_switch ? want : slot_reg;
        push_stats.slot_switched = do_switch;
        push_sum                 = sum_next;
        push_frames              = frames_next;
    end

    // accumulators and vote state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_l_reg   <= '0;
            nz_r_reg   <= '0;
            lv_l_reg   <= '0;
            lv_r_reg   <= '0;
            frames_reg <= '0;
            sum_reg    <= '0;
            slot_reg   <= SLOT_LEFT;
            vote_reg   <= '0;
            limit_reg  <= VOTE_LIMIT_RESET;
        end
        else
        begin
            if (cfg_valid)
                limit_reg <= vote_limit;
            if (fire)
            begin
                if (closes)
                begin
                    nz_l_reg   <= '0;
                    nz_r_reg   <= '0;
                    lv_l_reg   <= '0;
                    lv_r_reg   <= '0;
                    frames_reg <= '0;
                    sum_reg    <= '0;
                    if (want == slot_reg)
                        vote_reg <= '0;
                    else if (do_switch)
                    begin
                        slot_reg <= want;
                        vote_reg <= '0;
                    end
                    else
                        vote_reg <= vote_inc;
                end
                else
                begin
                    nz_l_reg   <= nz_l_next;
                    nz_r_reg   <= nz_r_next;
                    lv_l_reg   <= lv_l_next;
                    lv_r_reg   <= lv_r_next;
                    frames_reg <= frames_next;
                    sum_reg    <= sum_next;
                end
            end
        end
    end

    // extremes need no reset, the first frame of a block loads them
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

`ifndef SYNTHESIS
    a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> frames_reg == '0)
        else $error("frame count not cleared after block close");
    a_switch_clears_vote: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_stats.slot_switched |=> vote_reg == '0 && slot_reg == $past(want))
        else $error("slot switch did not clear vote count");
`endif

endmodule

[hw/rtl/msd_queue.sv]
// two-entry queue of closed block records between front and back
module msd_queue #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);
    logic [W-1:0] mem [2];
    logic         wr_ptr_reg, rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");
`endif

endmodule

[hw/rtl/msd_back.sv]
// back end: bit-serial mean division and the result register
module msd_back #(
    parameter int CNT_W = 7,
    parameter int SUM_W = 31
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    output logic                                 pop,
    input  msd_pkg::blk_stats_t                  pop_stats,
    input  logic signed [SUM_W-1:0]              pop_sum,
    input  logic [CNT_W-1:0]                     pop_frames,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output msd_pkg::blk_stats_t                  res_stats,
    output logic signed [msd_pkg::SAMPLE_W-1:0]  res_mean
);
    import msd_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SIGN, ST_DONE} state_t;

    state_t                     state_reg;
    blk_stats_t                 stats_reg;
    logic [SUM_W-1:0]           quo_reg, quo_next;
    logic [CNT_W-1:0]           rem_reg, rem_next, frames_reg;
    logic [STEP_W-1:0]          step_reg;
    logic                       neg_reg, out_valid_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic [CNT_W:0]             rem_shift;
    logic                       ge;

    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = out_valid_reg;
    assign res_stats = stats_reg;
    assign res_mean  = mean_reg;

    // one restoring division step per cycle on the sum magnitude
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        ge        = rem_shift >= {1'b0, frames_reg};
        rem_next  = ge ? CNT_W'(rem_shift - {1'b0, frames_reg}) : rem_shift[CNT_W-1:0];
        quo_next  = {quo_reg[SUM_W-2:0], ge};
    end

    // sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        stats_reg  <= pop_stats;
                        neg_reg    <= pop_sum[SUM_W-1];
                        quo_reg    <= pop_sum[SUM_W-1] ? $unsigned(-pop_sum)
                                                       : $unsigned(pop_sum);
                        rem_reg    <= '0;
                        frames_reg <= pop_frames;
                        step_reg   <= '0;
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    quo_reg  <= quo_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_LAST)
                        state_reg <= ST_SIGN;
                end
                ST_SIGN:
                begin
                    mean_reg      <= SAMPLE_W'(neg_reg ? -quo_reg : quo_reg);
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    out_valid_reg <= 1'b0;
                    state_reg     <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_valid_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> state_reg == ST_DONE)
        else $error("result valid outside done state");
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> frames_reg != '0)
        else $error("division by an empty block");
`endif

endmodule

[hw/rtl/i2s_mic_slot_detector.sv]
// top level of the i2s mic slot detector
//
// Accepts one stereo frame per clock while the block queue has room. Each
// block (closed by block_end or after BLOCK_FRAMES frames) yields one result
// word with per-slot nonzero and live counts, min, max and mean of the chosen
// mic slot, the last raw frame and the slot vote outcome. The vote happens in
// the front end as the block closes, so the next block already samples the
// new slot. The mean comes from a bit-serial divider, with SUM_W equal to
// 24 + clog2(BLOCK_FRAMES + 1); up to two closed blocks wait in a queue ahead
// of it, so short blocks back-pressure the input only when both slots are
// taken. vote_limit is written through its own port, always ready; the user
// writes it only while the block is idle, which the block does not enforce.
module i2s_mic_slot_detector #(
    parameter int BLOCK_FRAMES = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [msd_pkg::WORD_W-1:0]    left_word,
    input  logic signed [msd_pkg::WORD_W-1:0]    right_word,
    input  logic                                 block_end,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [msd_pkg::VOTE_W-1:0]           vote_limit,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [msd_pkg::COUNT_W-1:0]          nonzero_left,
    output logic [msd_pkg::COUNT_W-1:0]          nonzero_right,
    output logic [msd_pkg::COUNT_W-1:0]          live_left,
    output logic [msd_pkg::COUNT_W-1:0]          live_right,
    output logic signed [msd_pkg::SAMPLE_W-1:0]  sample_min,
    output logic signed [msd_pkg::SAMPLE_W-1:0]  sample_max,
    output logic signed [msd_pkg::SAMPLE_W-1:0]  sample_mean,
    output logic signed [msd_pkg::WORD_W-1:0]    last_left,
    output logic signed [msd_pkg::WORD_W-1:0]    last_right,
    output logic                                 chosen_slot,
    output logic                                 slot_switched
);
    import msd_pkg::*;

    localparam int CNT_W = $clog2(BLOCK_FRAMES + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int Q_W   = $bits(blk_stats_t) + SUM_W + CNT_W;

    logic                    push, pop, q_full, q_empty;
    blk_stats_t              push_stats, q_stats, res_stats;
    logic signed [SUM_W-1:0] push_sum, q_sum;
    logic [CNT_W-1:0]        push_frames, q_frames;
    logic [Q_W-1:0]          q_in, q_out;

    assign cfg_ready = 1'b1;

    // frame intake and vote
    msd_front #(
        .BLOCK_FRAMES (BLOCK_FRAMES),
        .CNT_W        (CNT_W),
        .SUM_W        (SUM_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .left_word   (left_word),
        .right_word  (right_word),
        .block_end   (block_end),
        .cfg_valid   (cfg_valid),
        .vote_limit  (vote_limit),
        .q_full      (q_full),
        .push        (push),
        .push_stats  (push_stats),
        .push_sum    (push_sum),
        .push_frames (push_frames)
    );

    // block record queue
    assign q_in = {push_stats, push_sum, push_frames};
    assign {q_stats, q_sum, q_frames} = q_out;

    msd_queue #(
        .W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // mean division and result register
    msd_back #(
        .CNT_W (CNT_W),
        .SUM_W (SUM_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .pop        (pop),
        .pop_stats  (q_stats),
        .pop_sum    (q_sum),
        .pop_frames (q_frames),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .res_stats  (res_stats),
        .res_mean   (sample_mean)
    );

    // result word fields
    assign nonzero_left  = res_stats.nonzero_left;
    assign nonzero_right = res_stats.nonzero_right;
    assign live_left     = res_stats.live_left;
    assign live_right    = res_stats.live_right;
    assign sample_min    = res_stats.sample_min;
    assign sample_max    = res_stats.sample_max;
    assign last_left     = res_stats.last_left;
    assign last_right    = res_stats.last_right;
    assign chosen_slot   = res_stats.chosen_slot;
    assign slot_switched = res_stats.slot_switched;

endmodule
